### sv/mir_pkg.sv
package mir_pkg;

	localparam int WORD_W  = 7;
	localparam int TOTAL_W = 25;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 25'd16777216;
	localparam logic [WORD_W-1:0]  BUDGET_RESET = 7'd64;

	localparam logic REG_TOTAL  = 1'b0;
	localparam logic REG_BUDGET = 1'b1;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_ADVERT = 2'd2,
		CMD_GAPS   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic last_range;
		logic reversed;
	} cmd_info_t;

endpackage

### sv/mir_ram.sv
module mir_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/mir_front.sv
module mir_front #(
	parameter int ID_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_cmd,
	input  logic                 in_last_range,
	input  logic [ID_BITS-1:0]   in_first,
	input  logic [ID_BITS-1:0]   in_last,
	output logic                 q_valid,
	input  logic                 q_pop,
	output mir_pkg::cmd_info_t   q_info,
	output logic [ID_BITS-1:0]   q_first,
	output logic [ID_BITS-1:0]   q_last
);

	mir_pkg::cmd_info_t        info_q  [2];
	logic [ID_BITS-1:0]        first_q [2];
	logic [ID_BITS-1:0]        last_q  [2];
	logic                      wr_q;
	logic                      rd_q;
	logic [1:0]                cnt_q;
	logic                      push;
	mir_pkg::cmd_info_t        info_new;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_info   = info_q[rd_q];
	assign q_first  = first_q[rd_q];
	assign q_last   = last_q[rd_q];

	always_comb begin
		info_new.cmd        = mir_pkg::cmd_t'(in_cmd);
		info_new.last_range = in_last_range;
		info_new.reversed   = (in_first > in_last);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			info_q[wr_q]  <= info_new;
			first_q[wr_q] <= in_first;
			last_q[wr_q]  <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop && q_valid) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

endmodule

### sv/mir_engine.sv
module mir_engine #(
	parameter int HIST_DEPTH = 256,
	parameter int ID_BITS    = 24,
	parameter int MAX_BUDGET = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  mir_pkg::cmd_info_t            q_info,
	input  logic [ID_BITS-1:0]            q_first,
	input  logic [ID_BITS-1:0]            q_last,
	input  logic [mir_pkg::TOTAL_W-1:0]   total_ids,
	input  logic [mir_pkg::WORD_W-1:0]    budget_words,
	output logic                          m_valid,
	input  logic                          m_ready,
	output logic                          out_range_valid,
	output logic [ID_BITS-1:0]            out_first,
	output logic [ID_BITS-1:0]            out_last,
	output logic                          out_single,
	output logic [mir_pkg::WORD_W-1:0]    out_words,
	output logic [ID_BITS:0]              out_helpful,
	output logic [ID_BITS:0]              out_advertised,
	output logic                          out_rejected,
	output logic                          out_end
);

	localparam int IDX_W = $clog2(HIST_DEPTH);
	localparam int HC_W  = $clog2(HIST_DEPTH + 1);
	localparam int CW    = ID_BITS + 1;
	localparam int WW    = mir_pkg::WORD_W;
	localparam int RA_W  = $clog2(MAX_BUDGET);
	localparam int HW    = 2 * ID_BITS;
	localparam int RW    = 2 * ID_BITS + 1 + WW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ADV_PREV_RD, ST_ADV_PREV, ST_ADV_RD, ST_ADV_CHK,
		ST_GAP_RD, ST_GAP_CHK, ST_DRAIN_RD, ST_DRAIN_LD
	} state_t;

	state_t                state_q;
	mir_pkg::cmd_t         kind_q;
	logic                  last_q;
	logic                  rejected_q;
	logic [CW-1:0]         a_q;
	logic [CW-1:0]         b_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         cur_q;
	logic [HC_W-1:0]       walk_q;
	logic [HC_W-1:0]       gk_q;
	logic [HC_W-1:0]       count_q;
	logic                  prev_valid_q;
	logic [WW-1:0]         words_q;
	logic [WW-1:0]         gw_q;
	logic [WW-1:0]         n_q;
	logic [WW-1:0]         k_q;
	logic [CW-1:0]         helpful_q;
	logic [CW-1:0]         adv_q;
	logic [ID_BITS-1:0]    last_start_q;
	logic [ID_BITS-1:0]    last_end_q;

	logic [31:0]           tot_w;
	logic [31:0]           cap_w;
	logic [CW-1:0]         t_lim;
	logic [WW-1:0]         lim;

	logic                  h_we;
	logic [IDX_W-1:0]      h_waddr;
	logic [HW-1:0]         h_wdata;
	logic                  h_re;
	logic [IDX_W-1:0]      h_raddr;
	logic [HW-1:0]         h_rdata;
	logic [CW-1:0]         ss;
	logic [CW-1:0]         se;

	logic                  r_re;
	logic [RW-1:0]         r_wdata;
	logic [RW-1:0]         r_rdata;

	logic                  em_en;
	logic                  em_gap;
	logic [CW-1:0]         em_lo;
	logic [CW-1:0]         em_hi;
	logic [WW-1:0]         em_base;
	logic                  em_fire;
	logic                  em_single;
	logic [WW-1:0]         em_words;
	logic [CW-1:0]         hp_new;

	logic                  ap_rej;
	logic                  ap_add;
	logic                  out_free;
	logic                  item_done;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] acc,
			input logic [CW-1:0] lo, input logic [CW-1:0] hi);
		logic [CW:0] s;
		logic [CW:0] cap;
		s   = {1'b0, acc} + ({1'b0, hi} - {1'b0, lo}) + (CW + 1)'(1);
		cap = (CW + 1)'(1) << ID_BITS;
		return (s > cap) ? cap[CW-1:0] : s[CW-1:0];
	endfunction

	assign cap_w = 32'(1) << ID_BITS;
	assign tot_w = 32'(total_ids);
	assign t_lim = CW'((tot_w > cap_w) ? cap_w : tot_w);
	assign lim   = (budget_words > WW'(MAX_BUDGET)) ? WW'(MAX_BUDGET) : budget_words;

	assign ss = CW'(h_rdata[HW-1:ID_BITS]);
	assign se = CW'(h_rdata[ID_BITS-1:0]);

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_free = !m_valid || m_ready;

	mir_ram #(.WIDTH(HW), .DEPTH(HIST_DEPTH)) u_held (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	mir_ram #(.WIDTH(RW), .DEPTH(MAX_BUDGET)) u_results (
		.clk   (clk),
		.we    (em_fire),
		.waddr (n_q[RA_W-1:0]),
		.wdata (r_wdata),
		.re    (r_re),
		.raddr (k_q[RA_W-1:0]),
		.rdata (r_rdata)
	);

	always_comb begin
		ap_rej  = 1'b0;
		ap_add  = 1'b0;
		h_we    = 1'b0;
		h_waddr = IDX_W'(count_q);
		h_wdata = {q_first, q_last};
		if (q_info.reversed) begin
			ap_rej = 1'b1;
		end else if (count_q != '0 && CW'(q_first) <= CW'(last_end_q)) begin
			ap_rej = 1'b1;
		end else if (count_q != '0 && CW'(q_first) == CW'(last_end_q) + CW'(1)) begin
			h_we    = 1'b1;
			h_waddr = IDX_W'(count_q - HC_W'(1));
			h_wdata = {last_start_q, q_last};
		end else if (count_q >= HC_W'(HIST_DEPTH)) begin
			ap_rej = 1'b1;
		end else begin
			h_we   = 1'b1;
			ap_add = 1'b1;
		end
		if (!(q_pop && q_info.cmd == mir_pkg::CMD_APPEND)) begin
			h_we   = 1'b0;
			ap_add = 1'b0;
			ap_rej = 1'b0;
		end
	end

	always_comb begin
		h_re    = 1'b0;
		h_raddr = IDX_W'(walk_q);
		r_re    = 1'b0;
		em_en   = 1'b0;
		em_gap  = 1'b0;
		em_lo   = lo_q;
		em_hi   = b_q;
		unique case (state_q)
			ST_ADV_PREV_RD: begin
				h_re    = 1'b1;
				h_raddr = IDX_W'(walk_q - HC_W'(1));
			end
			ST_ADV_RD: begin
				if (walk_q == count_q) begin
					em_en = (lo_q <= b_q);
				end else begin
					h_re = 1'b1;
				end
			end
			ST_ADV_CHK: begin
				if (b_q < ss) begin
					em_en = (lo_q <= b_q);
				end else if (lo_q < ss) begin
					em_en = 1'b1;
					em_hi = ss - CW'(1);
				end
			end
			ST_GAP_RD: begin
				em_gap  = 1'b1;
				em_lo   = cur_q;
				em_hi   = t_lim - CW'(1);
				h_raddr = IDX_W'(gk_q);
				if (gk_q == count_q) begin
					em_en = (cur_q < t_lim);
				end else begin
					h_re = !(cur_q >= t_lim || gw_q >= lim);
				end
			end
			ST_GAP_CHK: begin
				em_gap = 1'b1;
				em_lo  = cur_q;
				em_hi  = ((ss - CW'(1)) > (t_lim - CW'(1))) ? t_lim - CW'(1) : ss - CW'(1);
				em_en  = (ss > cur_q);
			end
			ST_DRAIN_RD: begin
				r_re = (n_q != '0);
			end
			default: begin
			end
		endcase
	end

	assign em_base   = em_gap ? gw_q : words_q;
	assign em_fire   = em_en && (em_base < lim) && (n_q < WW'(MAX_BUDGET));
	assign em_single = !(em_hi > em_lo && (lim - em_base) >= WW'(2));
	assign em_words  = em_base + (em_single ? WW'(1) : WW'(2));
	assign r_wdata   = {em_lo[ID_BITS-1:0], em_single ? em_lo[ID_BITS-1:0] : em_hi[ID_BITS-1:0],
		em_single, em_words};
	assign hp_new    = sat_add(helpful_q, em_lo, em_hi);

	assign item_done = ((state_q == ST_DRAIN_RD) && n_q == '0 && out_free)
		|| ((state_q == ST_DRAIN_LD) && out_free && (k_q == n_q - WW'(1)));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_info.cmd;
			last_q <= q_info.last_range;
			a_q    <= CW'(q_first);
			b_q    <= CW'(q_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rejected_q      <= 1'b0;
			lo_q            <= '0;
			cur_q           <= '0;
			walk_q          <= '0;
			gk_q            <= '0;
			count_q         <= '0;
			prev_valid_q    <= 1'b0;
			words_q         <= '0;
			gw_q            <= '0;
			n_q             <= '0;
			k_q             <= '0;
			helpful_q       <= '0;
			adv_q           <= '0;
			last_start_q    <= '0;
			last_end_q      <= '0;
			m_valid         <= 1'b0;
			out_range_valid <= 1'b0;
			out_first       <= '0;
			out_last        <= '0;
			out_single      <= 1'b0;
			out_words       <= '0;
			out_helpful     <= '0;
			out_advertised  <= '0;
			out_rejected    <= 1'b0;
			out_end         <= 1'b0;
		end else begin
			if (m_ready) begin
				m_valid <= 1'b0;
			end
			if (em_fire) begin
				n_q <= n_q + WW'(1);
				if (em_gap) begin
					gw_q <= em_words;
				end else begin
					words_q <= em_words;
				end
			end
			if (em_en && !em_gap) begin
				helpful_q <= hp_new;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						rejected_q <= ap_rej;
						n_q        <= '0;
						k_q        <= '0;
						state_q    <= ST_DRAIN_RD;
						unique case (q_info.cmd)
							mir_pkg::CMD_CLEAR: begin
								count_q      <= '0;
								walk_q       <= '0;
								prev_valid_q <= 1'b0;
								words_q      <= '0;
								helpful_q    <= '0;
								adv_q        <= '0;
							end
							mir_pkg::CMD_APPEND: begin
								if (h_we) begin
									last_end_q <= q_last;
								end
								if (ap_add) begin
									last_start_q <= q_first;
									count_q      <= count_q + HC_W'(1);
								end
							end
							mir_pkg::CMD_ADVERT: begin
								if (!q_info.reversed) begin
									adv_q <= sat_add(adv_q, CW'(q_first), CW'(q_last));
									lo_q  <= CW'(q_first);
									if (prev_valid_q && walk_q != '0) begin
										state_q <= ST_ADV_PREV_RD;
									end else begin
										state_q <= ST_ADV_RD;
									end
								end
							end
							mir_pkg::CMD_GAPS: begin
								cur_q   <= '0;
								gw_q    <= '0;
								gk_q    <= '0;
								state_q <= ST_GAP_RD;
							end
						endcase
					end
				end
				ST_ADV_PREV_RD: begin
					state_q <= ST_ADV_PREV;
				end
				ST_ADV_PREV: begin
					if (a_q <= se) begin
						lo_q <= se + CW'(1);
					end
					state_q <= ST_ADV_RD;
				end
				ST_ADV_RD: begin
					state_q <= (walk_q == count_q) ? ST_DRAIN_RD : ST_ADV_CHK;
				end
				ST_ADV_CHK: begin
					if (b_q < ss || b_q <= se) begin
						state_q <= ST_DRAIN_RD;
					end else begin
						if (lo_q < se + CW'(1)) begin
							lo_q <= se + CW'(1);
						end
						walk_q       <= walk_q + HC_W'(1);
						prev_valid_q <= 1'b1;
						state_q      <= ST_ADV_RD;
					end
				end
				ST_GAP_RD: begin
					state_q <= h_re ? ST_GAP_CHK : ST_DRAIN_RD;
				end
				ST_GAP_CHK: begin
					if (se + CW'(1) > cur_q) begin
						cur_q <= se + CW'(1);
					end
					gk_q    <= gk_q + HC_W'(1);
					state_q <= ST_GAP_RD;
				end
				ST_DRAIN_RD: begin
					if (n_q == '0) begin
						if (out_free) begin
							m_valid         <= 1'b1;
							out_range_valid <= 1'b0;
							out_first       <= '0;
							out_last        <= '0;
							out_single      <= 1'b0;
							out_words       <= (kind_q == mir_pkg::CMD_GAPS) ? gw_q : words_q;
							out_helpful     <= helpful_q;
							out_advertised  <= adv_q;
							out_rejected    <= rejected_q;
							out_end         <= 1'b1;
						end
					end else begin
						state_q <= ST_DRAIN_LD;
					end
				end
				ST_DRAIN_LD: begin
					if (out_free) begin
						m_valid         <= 1'b1;
						out_range_valid <= 1'b1;
						out_first       <= r_rdata[RW-1 -: ID_BITS];
						out_last        <= r_rdata[RW-ID_BITS-1 -: ID_BITS];
						out_single      <= r_rdata[WW];
						out_words       <= r_rdata[WW-1:0];
						out_helpful     <= helpful_q;
						out_advertised  <= adv_q;
						out_rejected    <= 1'b0;
						out_end         <= (k_q == n_q - WW'(1));
						k_q             <= k_q + WW'(1);
						state_q         <= ST_DRAIN_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (item_done) begin
				state_q <= ST_IDLE;
				if (kind_q == mir_pkg::CMD_ADVERT && last_q) begin
					walk_q       <= '0;
					prev_valid_q <= 1'b0;
					words_q      <= '0;
					helpful_q    <= '0;
					adv_q        <= '0;
				end
			end
		end
	end

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q <= count_q)
		else $error("walk position beyond the held table");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= HC_W'(HIST_DEPTH))
		else $error("held table count beyond its depth");

	a_drain_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN_LD |-> k_q < n_q)
		else $error("result buffer read past its fill");

	a_one_end: assert property (@(posedge clk) disable iff (!arst_n)
		item_done |=> state_q == ST_IDLE && m_valid && out_end)
		else $error("item finished without a closing transaction");

endmodule

### sv/missing_id_range_requester.sv
// Missing-ID range requester. Items arrive on the s_ stream: s_tuser carries the command,
// s_tdata the first and last ID, s_tlast closes an advertised request. Each item gives one
// or more transactions on the m_ stream, the final one flagged by m_tlast. Ranges emitted
// by one item are buffered, then sent with the running counts as they stand after that item.
// An advertised range reads and checks each held entry that it walks past, a gaps command
// each held entry it needs, and each emitted range is then read out of the result buffer;
// the held-range memory has a single registered read port. One item is worked on at a time,
// while a two-deep input queue and the output register keep both sides moving during a stall.
// A stalled receiver holds the output register and stops the drain; nothing is dropped.
// Reset empties the table, clears the request state and restores the registers to 2^24 IDs
// and 64 words; no clearing pass is needed. Registers sit on the APB port at 0 (total_ids)
// and 4 (budget_words); the user must write them only while the block is idle; it does not enforce this.
module missing_id_range_requester #(
	parameter int HIST_DEPTH = 256,
	parameter int ID_BITS    = 24,
	parameter int MAX_BUDGET = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// first_id, last_id
	input  logic [((2*ID_BITS+7)/8)*8-1:0]        s_tdata,
	// cmd
	input  logic [1:0]                            s_tuser,
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// range_first, range_last, words_used, helpful_count, advertised_count, append_rejected
	output logic [((4*ID_BITS+17)/8)*8-1:0]       m_tdata,
	// range_valid, is_single
	output logic [1:0]                            m_tuser,
	output logic                                  m_tlast,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	localparam int OUT_W = ((4*ID_BITS+17)/8)*8;

	logic [mir_pkg::TOTAL_W-1:0] total_q;
	logic [mir_pkg::WORD_W-1:0]  budget_q;
	logic                        q_valid;
	logic                        q_pop;
	mir_pkg::cmd_info_t          q_info;
	logic [ID_BITS-1:0]          q_first;
	logic [ID_BITS-1:0]          q_last;
	logic                        o_rv;
	logic [ID_BITS-1:0]          o_first;
	logic [ID_BITS-1:0]          o_last;
	logic                        o_single;
	logic [mir_pkg::WORD_W-1:0]  o_words;
	logic [ID_BITS:0]            o_help;
	logic [ID_BITS:0]            o_adv;
	logic                        o_rej;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == mir_pkg::REG_BUDGET) ? 32'(budget_q) : 32'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= mir_pkg::TOTAL_RESET;
			budget_q <= mir_pkg::BUDGET_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == mir_pkg::REG_TOTAL) begin
				total_q <= pwdata[mir_pkg::TOTAL_W-1:0];
			end else begin
				budget_q <= pwdata[mir_pkg::WORD_W-1:0];
			end
		end
	end

	mir_front #(.ID_BITS(ID_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_cmd        (s_tuser),
		.in_last_range (s_tlast),
		.in_first      (s_tdata[ID_BITS-1:0]),
		.in_last       (s_tdata[2*ID_BITS-1:ID_BITS]),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_info        (q_info),
		.q_first       (q_first),
		.q_last        (q_last)
	);

	mir_engine #(
		.HIST_DEPTH (HIST_DEPTH),
		.ID_BITS    (ID_BITS),
		.MAX_BUDGET (MAX_BUDGET)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_info          (q_info),
		.q_first         (q_first),
		.q_last          (q_last),
		.total_ids       (total_q),
		.budget_words    (budget_q),
		.m_valid         (m_tvalid),
		.m_ready         (m_tready),
		.out_range_valid (o_rv),
		.out_first       (o_first),
		.out_last        (o_last),
		.out_single      (o_single),
		.out_words       (o_words),
		.out_helpful     (o_help),
		.out_advertised  (o_adv),
		.out_rejected    (o_rej),
		.out_end         (m_tlast)
	);

	assign m_tdata = OUT_W'({o_rej, o_adv, o_help, o_words, o_last, o_first});
	assign m_tuser = {o_single, o_rv};

endmodule

### tb/sv/mir_checker.sv
module mir_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [47:0]  s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           errors,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 256;
	localparam int unsigned WORD_CAP = 64;
	localparam longint unsigned COUNT_CAP = 64'd1 << 24;

	typedef struct packed {
		logic        range_valid;
		logic [23:0] range_first;
		logic [23:0] range_last;
		logic        is_single;
		logic [6:0]  words_used;
		logic [24:0] helpful_count;
		logic [24:0] advertised_count;
		logic        append_rejected;
		logic        last_result;
	} range_result_t;

	int unsigned held_lo [DEPTH];
	int unsigned held_hi [DEPTH];
	int unsigned held_n;
	int unsigned walk_pos;
	bit          walk_started;
	int unsigned req_words;
	int unsigned helpful_sum;
	int unsigned offered_sum;
	int unsigned total_ids;
	int unsigned budget_words;
	range_result_t burst [$];
	range_result_t expected_ranges [$];

	initial begin
		held_n = 0;
		walk_pos = 0;
		walk_started = 0;
		req_words = 0;
		helpful_sum = 0;
		offered_sum = 0;
		total_ids = mir_pkg::TOTAL_RESET;
		budget_words = mir_pkg::BUDGET_RESET;
		errors = 0;
		pending = 0;
	end

	function automatic int unsigned sat_add(int unsigned x, longint unsigned n);
		longint unsigned s;
		s = x + n;
		return (s > COUNT_CAP) ? COUNT_CAP : s;
	endfunction

	function automatic int unsigned word_limit();
		return (budget_words > WORD_CAP) ? WORD_CAP : budget_words;
	endfunction

	function automatic void emit_range(ref int unsigned words, input int unsigned lo,
			input int unsigned hi);
		range_result_t r;
		int unsigned lim;
		bit one;
		lim = word_limit();
		if (words >= lim || burst.size() >= WORD_CAP)
			return;
		one = !(hi > lo && lim - words >= 2);
		r = '0;
		r.range_valid = 1'b1;
		r.range_first = lo[23:0];
		r.range_last = one ? lo[23:0] : hi[23:0];
		r.is_single = one;
		words += one ? 1 : 2;
		r.words_used = words[6:0];
		burst.push_back(r);
	endfunction

	function automatic void restart_request();
		walk_pos = 0;
		walk_started = 0;
		req_words = 0;
		helpful_sum = 0;
		offered_sum = 0;
	endfunction

	function automatic void take_missing(int unsigned lo, int unsigned hi);
		if (lo > hi)
			return;
		helpful_sum = sat_add(helpful_sum, longint'(hi) - lo + 1);
		emit_range(req_words, lo, hi);
	endfunction

	function automatic void offer_range(int unsigned a, int unsigned b);
		int unsigned lo, ss, se;
		lo = a;
		if (a > b)
			return;
		offered_sum = sat_add(offered_sum, longint'(b) - a + 1);
		if (walk_pos > held_n)
			walk_pos = held_n;
		if (walk_started && walk_pos > 0 && a <= held_hi[walk_pos-1])
			lo = held_hi[walk_pos-1] + 1;
		while (walk_pos < held_n) begin
			ss = held_lo[walk_pos];
			se = held_hi[walk_pos];
			if (b < ss) begin
				take_missing(lo, b);
				return;
			end
			if (lo < ss)
				take_missing(lo, ss - 1);
			if (b <= se)
				return;
			if (lo < se + 1)
				lo = se + 1;
			walk_pos++;
			walk_started = 1;
		end
		take_missing(lo, b);
	endfunction

	function automatic void list_gaps(ref int unsigned words);
		int unsigned t, cur, hi;
		t = (total_ids > COUNT_CAP) ? COUNT_CAP : total_ids;
		cur = 0;
		for (int unsigned k = 0; k < held_n; k++) begin
			if (cur >= t || words >= word_limit())
				return;
			if (held_lo[k] > cur) begin
				hi = held_lo[k] - 1;
				if (hi > t - 1)
					hi = t - 1;
				emit_range(words, cur, hi);
			end
			if (held_hi[k] + 1 > cur)
				cur = held_hi[k] + 1;
		end
		if (cur < t)
			emit_range(words, cur, t - 1);
	endfunction

	function automatic bit append_held(int unsigned a, int unsigned b);
		if (a > b)
			return 1;
		if (held_n > 0) begin
			if (a <= held_hi[held_n-1])
				return 1;
			if (a == held_hi[held_n-1] + 1) begin
				held_hi[held_n-1] = b;
				return 0;
			end
		end
		if (held_n >= DEPTH)
			return 1;
		held_lo[held_n] = a;
		held_hi[held_n] = b;
		held_n++;
		return 0;
	endfunction

	function automatic void predict_ranges(mir_pkg::cmd_t cmd, int unsigned a, int unsigned b,
			bit last);
		range_result_t r;
		bit rejected;
		int unsigned gap_words, shown;
		rejected = 0;
		gap_words = 0;
		burst.delete();
		case (cmd)
			mir_pkg::CMD_CLEAR: begin
				held_n = 0;
				restart_request();
			end
			mir_pkg::CMD_APPEND: rejected = append_held(a, b);
			mir_pkg::CMD_ADVERT: offer_range(a, b);
			default: list_gaps(gap_words);
		endcase
		shown = (cmd == mir_pkg::CMD_GAPS) ? gap_words : req_words;
		if (burst.size() == 0) begin
			r = '0;
			r.words_used = shown[6:0];
			r.append_rejected = rejected;
			burst.push_back(r);
		end
		foreach (burst[k]) begin
			r = burst[k];
			r.helpful_count = helpful_sum[24:0];
			r.advertised_count = offered_sum[24:0];
			r.last_result = (k == burst.size() - 1);
			expected_ranges.push_back(r);
		end
		if (cmd == mir_pkg::CMD_ADVERT && last)
			restart_request();
	endfunction

	always @(negedge clk) begin
		range_result_t got, want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == mir_pkg::REG_BUDGET)
					budget_words = pwdata[6:0];
				else
					total_ids = pwdata[24:0];
			end
			if (s_tvalid && s_tready)
				predict_ranges(mir_pkg::cmd_t'(s_tuser), s_tdata[23:0], s_tdata[47:24],
					s_tlast);
			if (m_tvalid && m_tready) begin
				got.range_valid = m_tuser[0];
				got.is_single = m_tuser[1];
				got.range_first = m_tdata[23:0];
				got.range_last = m_tdata[47:24];
				got.words_used = m_tdata[54:48];
				got.helpful_count = m_tdata[79:55];
				got.advertised_count = m_tdata[104:80];
				got.append_rejected = m_tdata[105];
				got.last_result = m_tlast;
				if (expected_ranges.size() == 0) begin
					errors++;
					$display("%0t unexpected transaction: expected none, actual %p", $realtime, got);
				end else begin
					want = expected_ranges.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t mismatch: expected %p, actual %p", $realtime, want, got);
					end
				end
			end
			pending = expected_ranges.size();
		end
	end
endmodule

### tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int MODE_NONE = 0;
	localparam int MODE_SEND = 1;
	localparam int MODE_RECV = 2;
	localparam int MODE_BOTH = 3;
	localparam int MAX_ID = 24'hFFFFFF;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [47:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         s_tlast = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [111:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         psel = 0;
	logic         penable = 0;
	logic         pwrite = 0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	int           errors;
	int           pending;
	int           idle_mode = MODE_NONE;
	bit           hold_go = 0;
	int           hold_left = 0;
	int           quiet_cycles = 0;
	int unsigned  totals [6] = '{32'h01FFFFFF, 1, 1000, 16777216, 5000000, 37};
	int unsigned  budgets [6] = '{100, 1, 2, 3, 64, 0};
	int           modes [6] = '{MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH, MODE_NONE,
		MODE_RECV};

	always #1 clk = ~clk;

	missing_id_range_requester dut (.*);

	mir_checker checker_i (.*);

	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= !((idle_mode == MODE_RECV && $urandom_range(99) < 67)
				|| (idle_mode == MODE_BOTH && $urandom_range(99) < 14));
	end

	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(logic index, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(mir_pkg::cmd_t cmd, int unsigned a, int unsigned b, bit last);
		bit taken;
		if ((idle_mode == MODE_SEND && $urandom_range(99) < 67)
			|| (idle_mode == MODE_BOTH && $urandom_range(99) < 14))
		begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {b[23:0], a[23:0]};
		s_tlast <= last;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(posedge clk);
	endtask

	// One well-formed request: a fresh table of ascending ranges, a gaps listing and ascending
	// advertised ranges, noise mixed in; a final item that is not noise carries the last flag.
	task automatic random_request(ref int sent);
		int unsigned scale, cur, lo, hi, n;
		scale = $urandom_range(1) ? 30 : 400000;
		send_item(mir_pkg::CMD_CLEAR, $urandom, $urandom, $urandom_range(1));
		sent++;
		cur = $urandom_range(scale);
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++) begin
			lo = cur + ($urandom_range(3) == 0 ? 0 : $urandom_range(1, scale));
			hi = lo + $urandom_range(scale);
			if (hi > MAX_ID)
				break;
			send_item(mir_pkg::CMD_APPEND, lo, hi, $urandom_range(1));
			sent++;
			cur = hi + 1;
		end
		send_item(mir_pkg::CMD_GAPS, $urandom, $urandom, $urandom_range(1));
		sent++;
		cur = 0;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15) begin
				send_item(mir_pkg::cmd_t'($urandom_range(3)), $urandom, $urandom,
					$urandom_range(1));
			end else begin
				lo = cur + $urandom_range(2 * scale);
				hi = lo + $urandom_range(2 * scale);
				if (hi > MAX_ID)
					hi = MAX_ID;
				if (lo > MAX_ID)
					lo = MAX_ID;
				send_item(mir_pkg::CMD_ADVERT, lo, hi, i == n - 1);
				cur = hi + 1;
			end
			sent++;
		end
	endtask

	initial begin
		int sent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(mir_pkg::CMD_GAPS, 0, 0, 0);
		send_item(mir_pkg::CMD_ADVERT, 0, MAX_ID, 0);
		send_item(mir_pkg::CMD_APPEND, 5, 3, 0);
		send_item(mir_pkg::CMD_APPEND, 10, 20, 0);
		send_item(mir_pkg::CMD_APPEND, 15, 30, 0);
		send_item(mir_pkg::CMD_APPEND, 21, 25, 0);
		send_item(mir_pkg::CMD_APPEND, 40, 40, 1);
		send_item(mir_pkg::CMD_APPEND, 100, MAX_ID, 0);
		send_item(mir_pkg::CMD_GAPS, MAX_ID, 0, 1);
		send_item(mir_pkg::CMD_ADVERT, 0, 60, 0);
		send_item(mir_pkg::CMD_ADVERT, 5, 9, 0);
		send_item(mir_pkg::CMD_ADVERT, 50, 40, 0);
		send_item(mir_pkg::CMD_ADVERT, 41, 41, 0);
		send_item(mir_pkg::CMD_ADVERT, 42, MAX_ID, 1);
		send_item(mir_pkg::CMD_ADVERT, MAX_ID, MAX_ID, 1);
		send_item(mir_pkg::CMD_CLEAR, MAX_ID, MAX_ID, 1);
		send_item(mir_pkg::CMD_APPEND, MAX_ID, MAX_ID, 0);
		send_item(mir_pkg::CMD_GAPS, 0, 0, 0);
		send_item(mir_pkg::CMD_CLEAR, 0, 0, 0);

		// Build a long table while the receiver holds off.
		hold_go = 1;
		for (int i = 0; i < 120; i++)
			send_item(mir_pkg::CMD_APPEND, 3 * i + 1, 3 * i + 1, 0);
		send_item(mir_pkg::CMD_GAPS, 0, 0, 0);
		send_item(mir_pkg::CMD_ADVERT, 0, 2000, 1);
		drain();

		for (int p = 0; p < 6; p++) begin
			idle_mode = modes[p];
			write_reg(mir_pkg::REG_TOTAL, totals[p]);
			write_reg(mir_pkg::REG_BUDGET, budgets[p]);
			sent = 0;
			while (sent < 18)
				random_request(sent);
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

### missing_id_range_requester.f
sv/mir_pkg.sv
sv/mir_ram.sv
sv/mir_front.sv
sv/mir_engine.sv
sv/missing_id_range_requester.sv
tb/sv/mir_checker.sv
tb/sv/tb_top.sv
